// ----- sv/hhsv_pkg.sv -----
`default_nettype none

package hhsv_pkg;

    // Field widths of the input and output words.
    localparam int unsigned SEED_W        = 24;
    localparam int unsigned AREA_W        = 3;
    localparam int unsigned CHAN_W        = 16;

    localparam int unsigned FRAC_BITS_DEF = 16;

    // Area table, in hundredths of one.
    localparam int unsigned AREA_N = 5;
    localparam int unsigned MIN_SAT_H [AREA_N] = '{15, 30, 40, 55, 5};
    localparam int unsigned MAX_BRI_H [AREA_N] = '{85, 95, 100, 100, 80};
    localparam int unsigned HUNDRED   = 100;

    // A byte read as a fraction is over 255, and the hue circle has six
    // sectors of 255 steps each once the hue is multiplied by six.
    localparam int unsigned DIV_BASE   = 255;
    localparam int unsigned ROUND_255  = 127;
    localparam int unsigned HUE_MUL    = 6;

    // Divider by 255: operand width and the number of folds it needs.
    localparam int unsigned DIV_W      = 34;
    localparam int unsigned DIV_FOLDS  = 5;

    localparam int unsigned CH_N = 3;
    localparam int unsigned CH_R = 0;
    localparam int unsigned CH_G = 1;
    localparam int unsigned CH_B = 2;

    typedef enum logic [2:0] {
        SEC_RY = 3'd0,
        SEC_YG = 3'd1,
        SEC_GC = 3'd2,
        SEC_CB = 3'd3,
        SEC_BM = 3'd4,
        SEC_MR = 3'd5
    } t_sector;

    // Exact floor(n / 255). Since 256 = 255 + 1, n = 256a + b equals
    // 255a + (a + b); each fold moves a into the quotient and leaves a much
    // smaller remainder. After the folds the remainder is below 2 * 255.
    function automatic logic [DIV_W-1:0] div255(input logic [DIV_W-1:0] i_n);
        logic [DIV_W-1:0] q;
        logic [DIV_W-1:0] r;
        q = '0;
        r = i_n;
        for (int k = 0; k < DIV_FOLDS; k++) begin
            q = q + (r >> 8);
            r = (r >> 8) + DIV_W'(r[7:0]);
        end
        if (r >= DIV_W'(DIV_BASE)) begin
            q = q + DIV_W'(1);
        end
        return q;
    endfunction

endpackage

`default_nettype wire

// ----- sv/hhsv_if.sv -----
`default_nettype none

interface hhsv_in_if;
    logic                               valid;
    logic                               ready;
    logic [hhsv_pkg::SEED_W-1:0]        seed;
    logic [hhsv_pkg::AREA_W-1:0]        area;

    modport source (output valid, output seed, output area, input ready);
    modport sink   (input valid, input seed, input area, output ready);
endinterface

interface hhsv_out_if;
    logic                               valid;
    logic                               ready;
    logic [hhsv_pkg::CHAN_W-1:0]        red;
    logic [hhsv_pkg::CHAN_W-1:0]        green;
    logic [hhsv_pkg::CHAN_W-1:0]        blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

// ----- sv/hashed_hsv_color_generator_core.sv -----
`default_nettype none

// Seeded HSV color generator: each input word carries a 24-bit seed (hue in
// bits 7:0, saturation in 15:8, value in 23:16) and an area code that picks a
// minimum saturation and a brightness cap (codes above 4 use area 0), and
// each produces one output word with red, green and blue as 16-bit fractions
// of one. The datapath is a seven-stage pipeline with one word per clock
// sustained while the output side does not stall; an accepted word passes
// through the stage registers in order. The stages are the area lookup with
// the byte products and hue sector, the two divide-by-255 stages (saturation
// and value share the second, the secondary component the fifth), the two
// multiplier stages between them, the sector mix and the rescale to 16 bits.
// The last stage is the output register, and the whole pipeline holds while
// a finished word waits there, so input ready is low only in that case.
// FRAC_BITS (8 to 24) sets the internal fraction precision. There is no
// state between words and nothing to clear after reset.
module hashed_hsv_color_generator_core #(
    parameter int unsigned FRAC_BITS = hhsv_pkg::FRAC_BITS_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    hhsv_in_if.sink     i_in,
    hhsv_out_if.source  o_out
);

    logic                       w_en;
    logic                       w_f_vld;
    logic [FRAC_BITS:0]         w_f_s;
    logic [FRAC_BITS:0]         w_f_v;
    hhsv_pkg::t_sector          w_f_sec;
    logic [7:0]                 w_f_w;
    logic                       w_c_vld;
    logic [FRAC_BITS:0]         w_c_c;
    logic [FRAC_BITS:0]         w_c_x;
    logic [FRAC_BITS:0]         w_c_m;
    hhsv_pkg::t_sector          w_c_sec;
    logic                       w_o_vld;

    // Every stage advances unless a finished word is waiting at the output.
    assign w_en       = !w_o_vld || o_out.ready;
    assign i_in.ready = w_en;
    assign o_out.valid = w_o_vld;

    hhsv_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_in.valid),
        .i_seed  (i_in.seed),
        .i_area  (i_in.area),
        .o_vld   (w_f_vld),
        .o_s     (w_f_s),
        .o_v     (w_f_v),
        .o_sec   (w_f_sec),
        .o_w     (w_f_w)
    );

    hhsv_chroma #(
        .FRAC_BITS (FRAC_BITS)
    ) u_chroma (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_f_vld),
        .i_s     (w_f_s),
        .i_v     (w_f_v),
        .i_sec   (w_f_sec),
        .i_w     (w_f_w),
        .o_vld   (w_c_vld),
        .o_c     (w_c_c),
        .o_x     (w_c_x),
        .o_m     (w_c_m),
        .o_sec   (w_c_sec)
    );

    hhsv_mix #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_c_vld),
        .i_c     (w_c_c),
        .i_x     (w_c_x),
        .i_m     (w_c_m),
        .i_sec   (w_c_sec),
        .o_vld   (w_o_vld),
        .o_red   (o_out.red),
        .o_green (o_out.green),
        .o_blue  (o_out.blue)
    );

endmodule

`default_nettype wire

// ----- sv/hhsv_front.sv -----
`default_nettype none

module hhsv_front #(
    parameter int unsigned FRAC_BITS = hhsv_pkg::FRAC_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_en,
    input  wire logic                           i_vld,
    input  wire logic [hhsv_pkg::SEED_W-1:0]    i_seed,
    input  wire logic [hhsv_pkg::AREA_W-1:0]    i_area,
    output logic                                o_vld,
    output logic [FRAC_BITS:0]                  o_s,
    output logic [FRAC_BITS:0]                  o_v,
    output hhsv_pkg::t_sector                   o_sec,
    output logic [7:0]                          o_w
);

    localparam int unsigned     FW    = FRAC_BITS + 1;
    localparam int unsigned     PW    = FRAC_BITS + 9;
    localparam longint unsigned ONE   = 64'd1 << FRAC_BITS;
    localparam longint unsigned HALFH = 64'(hhsv_pkg::HUNDRED / 2);
    localparam longint unsigned HUND  = 64'(hhsv_pkg::HUNDRED);
    localparam logic [FW-1:0]   ONE_V = FW'(ONE);
    localparam int unsigned     SEG   = hhsv_pkg::DIV_BASE;

    localparam logic [FW-1:0] MS_TAB [hhsv_pkg::AREA_N] = '{
        FW'((64'(hhsv_pkg::MIN_SAT_H[0]) * ONE + HALFH) / HUND),
        FW'((64'(hhsv_pkg::MIN_SAT_H[1]) * ONE + HALFH) / HUND),
        FW'((64'(hhsv_pkg::MIN_SAT_H[2]) * ONE + HALFH) / HUND),
        FW'((64'(hhsv_pkg::MIN_SAT_H[3]) * ONE + HALFH) / HUND),
        FW'((64'(hhsv_pkg::MIN_SAT_H[4]) * ONE + HALFH) / HUND)
    };
    localparam logic [FW-1:0] MB_TAB [hhsv_pkg::AREA_N] = '{
        FW'((64'(hhsv_pkg::MAX_BRI_H[0]) * ONE + HALFH) / HUND),
        FW'((64'(hhsv_pkg::MAX_BRI_H[1]) * ONE + HALFH) / HUND),
        FW'((64'(hhsv_pkg::MAX_BRI_H[2]) * ONE + HALFH) / HUND),
        FW'((64'(hhsv_pkg::MAX_BRI_H[3]) * ONE + HALFH) / HUND),
        FW'((64'(hhsv_pkg::MAX_BRI_H[4]) * ONE + HALFH) / HUND)
    };

    // Stage 1: area lookup, the two byte products and the hue sector.
    logic [2:0]                 n_ix;
    logic [FW-1:0]              n_ms;
    logic [PW-1:0]              n_ps;
    logic [PW-1:0]              n_pv;
    logic [10:0]                n_h6;
    logic [8:0]                 n_t;
    logic [7:0]                 n_w;
    hhsv_pkg::t_sector          n_sec;

    logic                       r1_vld;
    logic [PW-1:0]              r1_ps;
    logic [PW-1:0]              r1_pv;
    logic [FW-1:0]              r1_ms;
    hhsv_pkg::t_sector          r1_sec;
    logic [7:0]                 r1_w;

    always_comb begin
        n_ix  = (i_area > 3'(hhsv_pkg::AREA_N - 1)) ? 3'd0 : i_area;
        n_ms  = MS_TAB[n_ix];
        n_ps  = PW'(i_seed[15:8]) * PW'(ONE_V - n_ms) + PW'(hhsv_pkg::ROUND_255);
        n_pv  = PW'(i_seed[23:16]) * PW'(MB_TAB[n_ix]) + PW'(hhsv_pkg::ROUND_255);
        n_h6  = 11'(i_seed[7:0]) * 11'(hhsv_pkg::HUE_MUL);

        // The top hue lands on 6 * 255 and is kept in the last sector.
        if (n_h6 >= 11'(5 * SEG)) begin
            n_sec = hhsv_pkg::SEC_MR;
        end else if (n_h6 >= 11'(4 * SEG)) begin
            n_sec = hhsv_pkg::SEC_BM;
        end else if (n_h6 >= 11'(3 * SEG)) begin
            n_sec = hhsv_pkg::SEC_CB;
        end else if (n_h6 >= 11'(2 * SEG)) begin
            n_sec = hhsv_pkg::SEC_GC;
        end else if (n_h6 >= 11'(SEG)) begin
            n_sec = hhsv_pkg::SEC_YG;
        end else begin
            n_sec = hhsv_pkg::SEC_RY;
        end

        if (n_h6 >= 11'(4 * SEG)) begin
            n_t = 9'(n_h6 - 11'(4 * SEG));
        end else if (n_h6 >= 11'(2 * SEG)) begin
            n_t = 9'(n_h6 - 11'(2 * SEG));
        end else begin
            n_t = 9'(n_h6);
        end

        // Triangle weight 255 - |t - 255|.
        n_w = (n_t >= 9'(SEG)) ? 8'(9'(2 * SEG) - n_t) : n_t[7:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ps  <= n_ps;
            r1_pv  <= n_pv;
            r1_ms  <= n_ms;
            r1_sec <= n_sec;
            r1_w   <= n_w;
        end
    end

    // Stage 2: both divisions by 255.
    logic [hhsv_pkg::DIV_W-1:0] w_qs;
    logic [hhsv_pkg::DIV_W-1:0] w_qv;
    logic [FW-1:0]              n_s;
    logic [FW-1:0]              n_v;

    logic                       r2_vld;
    logic [FW-1:0]              r2_s;
    logic [FW-1:0]              r2_v;
    hhsv_pkg::t_sector          r2_sec;
    logic [7:0]                 r2_w;

    always_comb begin
        w_qs = hhsv_pkg::div255(hhsv_pkg::DIV_W'(r1_ps));
        w_qv = hhsv_pkg::div255(hhsv_pkg::DIV_W'(r1_pv));
        n_s  = r1_ms + w_qs[FW-1:0];
        n_v  = w_qv[FW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (i_en) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_s   <= n_s;
            r2_v   <= n_v;
            r2_sec <= r1_sec;
            r2_w   <= r1_w;
        end
    end

    assign o_vld = r2_vld;
    assign o_s   = r2_s;
    assign o_v   = r2_v;
    assign o_sec = r2_sec;
    assign o_w   = r2_w;

    a_sat_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r2_vld |-> (r2_s <= ONE_V))
        else $error("saturation above one");

    a_val_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r2_vld |-> (r2_v <= ONE_V))
        else $error("value above one");

endmodule

`default_nettype wire

// ----- sv/hhsv_chroma.sv -----
`default_nettype none

module hhsv_chroma #(
    parameter int unsigned FRAC_BITS = hhsv_pkg::FRAC_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_en,
    input  wire logic                   i_vld,
    input  wire logic [FRAC_BITS:0]     i_s,
    input  wire logic [FRAC_BITS:0]     i_v,
    input  wire hhsv_pkg::t_sector      i_sec,
    input  wire logic [7:0]             i_w,
    output logic                        o_vld,
    output logic [FRAC_BITS:0]          o_c,
    output logic [FRAC_BITS:0]          o_x,
    output logic [FRAC_BITS:0]          o_m,
    output hhsv_pkg::t_sector           o_sec
);

    localparam int unsigned     FW   = FRAC_BITS + 1;
    localparam int unsigned     MW   = 2 * FW;
    localparam int unsigned     XW   = FW + 8;
    localparam longint unsigned HALF = 64'd1 << (FRAC_BITS - 1);

    // Stage 3: chroma c = round(v * s), never above v.
    logic [MW-1:0]              n_prod;
    logic [FW-1:0]              n_craw;
    logic [FW-1:0]              n_c;

    logic                       r3_vld;
    logic [FW-1:0]              r3_c;
    logic [FW-1:0]              r3_v;
    hhsv_pkg::t_sector          r3_sec;
    logic [7:0]                 r3_w;

    always_comb begin
        n_prod = MW'(i_v) * MW'(i_s) + MW'(HALF);
        n_craw = n_prod[FRAC_BITS +: FW];
        n_c    = (n_craw > i_v) ? i_v : n_craw;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (i_en) begin
            r3_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_c   <= n_c;
            r3_v   <= i_v;
            r3_sec <= i_sec;
            r3_w   <= i_w;
        end
    end

    // Stage 4: product for the secondary component and the offset m.
    logic [XW-1:0]              n_xn;
    logic [FW-1:0]              n_m;

    logic                       r4_vld;
    logic [XW-1:0]              r4_xn;
    logic [FW-1:0]              r4_c;
    logic [FW-1:0]              r4_m;
    hhsv_pkg::t_sector          r4_sec;

    always_comb begin
        n_xn = XW'(r3_c) * XW'(r3_w) + XW'(hhsv_pkg::ROUND_255);
        n_m  = r3_v - r3_c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (i_en) begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_xn  <= n_xn;
            r4_c   <= r3_c;
            r4_m   <= n_m;
            r4_sec <= r3_sec;
        end
    end

    // Stage 5: x = round(c * w / 255).
    logic [hhsv_pkg::DIV_W-1:0] w_qx;

    logic                       r5_vld;
    logic [FW-1:0]              r5_x;
    logic [FW-1:0]              r5_c;
    logic [FW-1:0]              r5_m;
    hhsv_pkg::t_sector          r5_sec;

    assign w_qx = hhsv_pkg::div255(hhsv_pkg::DIV_W'(r4_xn));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else if (i_en) begin
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_x   <= w_qx[FW-1:0];
            r5_c   <= r4_c;
            r5_m   <= r4_m;
            r5_sec <= r4_sec;
        end
    end

    assign o_vld = r5_vld;
    assign o_c   = r5_c;
    assign o_x   = r5_x;
    assign o_m   = r5_m;
    assign o_sec = r5_sec;

    a_chroma_le_val: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r3_vld |-> (r3_c <= r3_v))
        else $error("chroma exceeds value");

    a_x_le_chroma: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r5_vld |-> (r5_x <= r5_c))
        else $error("secondary component exceeds chroma");

endmodule

`default_nettype wire

// ----- sv/hhsv_mix.sv -----
`default_nettype none

module hhsv_mix #(
    parameter int unsigned FRAC_BITS = hhsv_pkg::FRAC_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_en,
    input  wire logic                           i_vld,
    input  wire logic [FRAC_BITS:0]             i_c,
    input  wire logic [FRAC_BITS:0]             i_x,
    input  wire logic [FRAC_BITS:0]             i_m,
    input  wire hhsv_pkg::t_sector              i_sec,
    output logic                                o_vld,
    output logic [hhsv_pkg::CHAN_W-1:0]         o_red,
    output logic [hhsv_pkg::CHAN_W-1:0]         o_green,
    output logic [hhsv_pkg::CHAN_W-1:0]         o_blue
);

    localparam int unsigned     FW   = FRAC_BITS + 1;
    localparam int unsigned     CW   = hhsv_pkg::CHAN_W;
    localparam int unsigned     SW   = FW + CW;
    localparam longint unsigned HALF = 64'd1 << (FRAC_BITS - 1);

    // Stage 6: place c and x by sector and add the offset m.
    logic [FW-1:0]  n_sel [hhsv_pkg::CH_N];
    logic [FW-1:0]  n_ch  [hhsv_pkg::CH_N];

    logic           r6_vld;
    logic [FW-1:0]  r6_ch [hhsv_pkg::CH_N];
    logic [FW-1:0]  r6_v;

    always_comb begin
        unique case (i_sec)
            hhsv_pkg::SEC_RY: begin
                n_sel[hhsv_pkg::CH_R] = i_c;
                n_sel[hhsv_pkg::CH_G] = i_x;
                n_sel[hhsv_pkg::CH_B] = '0;
            end
            hhsv_pkg::SEC_YG: begin
                n_sel[hhsv_pkg::CH_R] = i_x;
                n_sel[hhsv_pkg::CH_G] = i_c;
                n_sel[hhsv_pkg::CH_B] = '0;
            end
            hhsv_pkg::SEC_GC: begin
                n_sel[hhsv_pkg::CH_R] = '0;
                n_sel[hhsv_pkg::CH_G] = i_c;
                n_sel[hhsv_pkg::CH_B] = i_x;
            end
            hhsv_pkg::SEC_CB: begin
                n_sel[hhsv_pkg::CH_R] = '0;
                n_sel[hhsv_pkg::CH_G] = i_x;
                n_sel[hhsv_pkg::CH_B] = i_c;
            end
            hhsv_pkg::SEC_BM: begin
                n_sel[hhsv_pkg::CH_R] = i_x;
                n_sel[hhsv_pkg::CH_G] = '0;
                n_sel[hhsv_pkg::CH_B] = i_c;
            end
            default: begin
                n_sel[hhsv_pkg::CH_R] = i_c;
                n_sel[hhsv_pkg::CH_G] = '0;
                n_sel[hhsv_pkg::CH_B] = i_x;
            end
        endcase
        for (int k = 0; k < hhsv_pkg::CH_N; k++) begin
            n_ch[k] = n_sel[k] + i_m;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else if (i_en) begin
            r6_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < hhsv_pkg::CH_N; k++) begin
                r6_ch[k] <= n_ch[k];
            end
            r6_v <= i_c + i_m;
        end
    end

    // Stage 7: rescale to 16 bits, ch * 65535 done as a shift and subtract.
    logic [SW-1:0]  n_sc  [hhsv_pkg::CH_N];
    logic [CW:0]    n_q   [hhsv_pkg::CH_N];
    logic [CW-1:0]  n_out [hhsv_pkg::CH_N];

    logic           r7_vld;
    logic [CW-1:0]  r7_out [hhsv_pkg::CH_N];

    always_comb begin
        for (int k = 0; k < hhsv_pkg::CH_N; k++) begin
            n_sc[k]  = {r6_ch[k], {CW{1'b0}}} - SW'(r6_ch[k]) + SW'(HALF);
            n_q[k]   = n_sc[k][FRAC_BITS +: (CW + 1)];
            n_out[k] = n_q[k][CW] ? {CW{1'b1}} : n_q[k][CW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_vld <= 1'b0;
        end else if (i_en) begin
            r7_vld <= r6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < hhsv_pkg::CH_N; k++) begin
                r7_out[k] <= n_out[k];
            end
        end
    end

    assign o_vld   = r7_vld;
    assign o_red   = r7_out[hhsv_pkg::CH_R];
    assign o_green = r7_out[hhsv_pkg::CH_G];
    assign o_blue  = r7_out[hhsv_pkg::CH_B];

    // The channel that carries the chroma always reaches the full value.
    a_peak_is_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r6_vld |-> (r6_ch[hhsv_pkg::CH_R] == r6_v || r6_ch[hhsv_pkg::CH_G] == r6_v
                    || r6_ch[hhsv_pkg::CH_B] == r6_v))
        else $error("no channel at full value");

endmodule

`default_nettype wire

// ----- sim/hashed_hsv_color_generator_core_tb.sv -----
`timescale 1ns / 1ps

module hashed_hsv_color_generator_core_tb;

    localparam int unsigned FRAC      = hhsv_pkg::FRAC_BITS_DEF;
    localparam bit [63:0]   ONE_FX    = 64'd1 << FRAC;
    localparam bit [63:0]   HALF_FX   = 64'd1 << (FRAC - 1);
    localparam bit [63:0]   CHAN_MAX  = (64'd1 << hhsv_pkg::CHAN_W) - 1;
    localparam int          RAND_N    = 880;
    localparam int          LONG_HOLD = 300;
    localparam int          DRAIN_MAX = 20000;
    localparam int          TAIL_WAIT = 16;
    localparam int          REPORT_N  = 10;

    typedef struct packed {
        logic [hhsv_pkg::CHAN_W-1:0] red;
        logic [hhsv_pkg::CHAN_W-1:0] green;
        logic [hhsv_pkg::CHAN_W-1:0] blue;
    } t_rgb;

    typedef struct packed {
        logic [hhsv_pkg::SEED_W-1:0] seed;
        logic [hhsv_pkg::AREA_W-1:0] area;
        bit                          known;
        t_rgb                        color;
    } t_probe;

    // Rows marked known carry a color that follows directly from the
    // conversion: zero value gives black, and full saturation and value in a
    // full-brightness area give pure primaries at the sector edges.
    localparam int     PROBE_N = 22;
    localparam t_probe PROBES [PROBE_N] = '{
        '{24'h000000, 3'd0, 1'b1, '{16'h0000, 16'h0000, 16'h0000}},
        '{24'h00FFFF, 3'd4, 1'b1, '{16'h0000, 16'h0000, 16'h0000}},
        '{24'h00A5C3, 3'd7, 1'b1, '{16'h0000, 16'h0000, 16'h0000}},
        '{24'hFFFF00, 3'd2, 1'b1, '{16'hFFFF, 16'h0000, 16'h0000}},
        '{24'hFFFF55, 3'd2, 1'b1, '{16'h0000, 16'hFFFF, 16'h0000}},
        '{24'hFFFFAA, 3'd3, 1'b1, '{16'h0000, 16'h0000, 16'hFFFF}},
        '{24'hFFFFFF, 3'd3, 1'b1, '{16'hFFFF, 16'h0000, 16'h0000}},
        '{24'hFFFFFF, 3'd0, 1'b0, '0},
        '{24'hFFFFFF, 3'd1, 1'b0, '0},
        '{24'hFFFFFF, 3'd4, 1'b0, '0},
        '{24'hFF00FF, 3'd5, 1'b0, '0},
        '{24'hFF0080, 3'd6, 1'b0, '0},
        '{24'h80802A, 3'd7, 1'b0, '0},
        '{24'h80802B, 3'd1, 1'b0, '0},
        '{24'hC0407F, 3'd2, 1'b0, '0},
        '{24'hC04080, 3'd3, 1'b0, '0},
        '{24'h7FE0D4, 3'd4, 1'b0, '0},
        '{24'h7FE0D5, 3'd0, 1'b0, '0},
        '{24'h01FF01, 3'd2, 1'b0, '0},
        '{24'hFF0100, 3'd1, 1'b0, '0},
        '{24'h123456, 3'd5, 1'b0, '0},
        '{24'hFEFEFE, 3'd6, 1'b0, '0}
    };

    logic i_clk;
    logic i_rst_n;

    hhsv_in_if  in_bus ();
    hhsv_out_if out_bus ();

    hashed_hsv_color_generator_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    t_rgb pending_colors [$];
    int   words_sent;
    int   colors_checked;
    int   error_count;
    bit   idle_en;
    bit   long_hold_req;
    bit   long_hold_done;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [hhsv_pkg::CHAN_W-1:0] frac_to_chan(input bit [63:0] frac);
        bit [63:0] scaled;
        scaled = (frac * CHAN_MAX + HALF_FX) >> FRAC;
        if (scaled > CHAN_MAX) begin
            scaled = CHAN_MAX;
        end
        return scaled[hhsv_pkg::CHAN_W-1:0];
    endfunction

    function automatic t_rgb predict_color(input logic [hhsv_pkg::SEED_W-1:0] seed,
                                           input logic [hhsv_pkg::AREA_W-1:0] area);
        bit [63:0]         hue, sat8, val8, sat_min, bri_max;
        bit [63:0]         sat, val, chroma, second, offset, phase, weight;
        bit [63:0]         r, g, b, sec_idx;
        int unsigned       row;
        hhsv_pkg::t_sector sector;
        t_rgb              color;
        row     = (area < hhsv_pkg::AREA_N) ? int'(area) : 0;
        sat_min = (64'(hhsv_pkg::MIN_SAT_H[row]) * ONE_FX + 64'd50) / hhsv_pkg::HUNDRED;
        bri_max = (64'(hhsv_pkg::MAX_BRI_H[row]) * ONE_FX + 64'd50) / hhsv_pkg::HUNDRED;
        hue     = 64'(seed[7:0]);
        sat8    = 64'(seed[15:8]);
        val8    = 64'(seed[23:16]);

        sat    = sat_min + (sat8 * (ONE_FX - sat_min) + hhsv_pkg::ROUND_255)
                 / hhsv_pkg::DIV_BASE;
        val    = (val8 * bri_max + hhsv_pkg::ROUND_255) / hhsv_pkg::DIV_BASE;
        chroma = (val * sat + HALF_FX) >> FRAC;
        if (chroma > val) begin
            chroma = val;
        end
        offset = val - chroma;

        // The position within a sector, as a triangle wave over 0..510.
        phase  = (hhsv_pkg::HUE_MUL * hue) % (2 * hhsv_pkg::DIV_BASE);
        weight = (phase >= hhsv_pkg::DIV_BASE) ? (2 * hhsv_pkg::DIV_BASE - phase) : phase;
        second = (chroma * weight + hhsv_pkg::ROUND_255) / hhsv_pkg::DIV_BASE;

        sec_idx = (hhsv_pkg::HUE_MUL * hue) / hhsv_pkg::DIV_BASE;
        sector  = (sec_idx > 5) ? hhsv_pkg::SEC_MR : hhsv_pkg::t_sector'(sec_idx[2:0]);
        case (sector)
            hhsv_pkg::SEC_RY: begin r = chroma; g = second; b = 0;      end
            hhsv_pkg::SEC_YG: begin r = second; g = chroma; b = 0;      end
            hhsv_pkg::SEC_GC: begin r = 0;      g = chroma; b = second; end
            hhsv_pkg::SEC_CB: begin r = 0;      g = second; b = chroma; end
            hhsv_pkg::SEC_BM: begin r = second; g = 0;      b = chroma; end
            default: begin r = chroma; g = 0;     b = second; end
        endcase
        color.red   = frac_to_chan(r + offset);
        color.green = frac_to_chan(g + offset);
        color.blue  = frac_to_chan(b + offset);
        return color;
    endfunction

    // Bytes cluster on the extremes and near the sector edges of the hue.
    function automatic logic [7:0] pick_byte();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 2) begin
            return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
        end else if (sel < 4) begin
            return 8'(42 * $urandom_range(0, 6) + $urandom_range(0, 2));
        end
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic note_error(input string msg);
        error_count++;
        if (error_count <= REPORT_N) begin
            $display("ERROR: %s", msg);
        end
    endtask

    // Called at a falling edge; returns at the falling edge after the word
    // has been taken.
    task automatic send_word(input logic [hhsv_pkg::SEED_W-1:0] seed,
                             input logic [hhsv_pkg::AREA_W-1:0] area,
                             input t_rgb color);
        if (idle_en && $urandom_range(0, 7) == 0) begin
            in_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
        in_bus.valid <= 1'b1;
        in_bus.seed  <= seed;
        in_bus.area  <= area;
        do begin
            @(posedge i_clk);
        end while (!in_bus.ready);
        pending_colors.push_back(color);
        words_sent++;
        @(negedge i_clk);
    endtask

    initial begin
        int hold_left;
        hold_left      = 0;
        long_hold_done = 1'b0;
        out_bus.ready  = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                out_bus.ready <= 1'b0;
                hold_left--;
            end else if (long_hold_req && !long_hold_done) begin
                long_hold_done = 1'b1;
                out_bus.ready <= 1'b0;
                hold_left = LONG_HOLD - 1;
            end else if (idle_en && $urandom_range(0, 9) == 0) begin
                out_bus.ready <= 1'b0;
                hold_left = $urandom_range(1, 16) - 1;
            end else begin
                out_bus.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_rgb got;
        t_rgb want;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            got = '{out_bus.red, out_bus.green, out_bus.blue};
            if (pending_colors.size() == 0) begin
                note_error($sformatf("color %h %h %h arrived with none pending",
                                     got.red, got.green, got.blue));
            end else begin
                want = pending_colors.pop_front();
                if (got.red !== want.red || got.green !== want.green ||
                        got.blue !== want.blue) begin
                    note_error($sformatf("color %0d: expected %h %h %h, got %h %h %h",
                                         colors_checked, want.red, want.green,
                                         want.blue, got.red, got.green, got.blue));
                end
                colors_checked++;
            end
        end
    end

    initial begin
        #1_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        logic [hhsv_pkg::SEED_W-1:0] seed;
        logic [hhsv_pkg::AREA_W-1:0] area;
        t_rgb                        color;
        int                          guard;
        i_clk          = 1'b0;
        words_sent     = 0;
        colors_checked = 0;
        error_count    = 0;
        long_hold_req  = 1'b0;
        idle_en        = 1'b1;
        in_bus.valid   = 1'b0;
        in_bus.seed    = '0;
        in_bus.area    = '0;
        i_rst_n        = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < PROBE_N; i++) begin
            color = PROBES[i].known ? PROBES[i].color
                                    : predict_color(PROBES[i].seed, PROBES[i].area);
            send_word(PROBES[i].seed, PROBES[i].area, color);
        end

        // Phases: idling, a clean stretch that also holds the long output
        // stall, idling again, and a clean tail.
        for (int i = 0; i < RAND_N; i++) begin
            idle_en = (i < 200) || (i >= 400 && i < RAND_N - 150);
            if (i == 300) begin
                long_hold_req = 1'b1;
            end
            seed = {pick_byte(), pick_byte(), pick_byte()};
            area = hhsv_pkg::AREA_W'($urandom_range(0, 7));
            send_word(seed, area, predict_color(seed, area));
        end
        in_bus.valid <= 1'b0;

        guard = 0;
        while (pending_colors.size() != 0 && guard < DRAIN_MAX) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (pending_colors.size() != 0) begin
            note_error($sformatf("%0d colors never arrived", pending_colors.size()));
        end

        $display("Sent %0d seeds over all areas, fallback codes and hue sector edges;",
                 words_sent);
        $display("checked %0d colors under random stalls and one long output hold.",
                 colors_checked);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
